[design/pflt_pkg.sv]
// Shared types and constants for the packet flow log table.
package pflt_pkg;

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // One table entry as stored.
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] l4_src;
        logic [15:0] l4_dst;
        logic [7:0]  proto;
        logic [2:0]  hook;
        logic [7:0]  action;
        logic [31:0] reason;
        logic [31:0] stamp;
        logic [31:0] count;
    } entry_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // latch input item, start scan at 0
        logic scan_step;  // compare entry at scan index, advance
        logic write_new;  // write new entry at fill or oldest slot
        logic write_hit;  // update matched entry
        logic read_req;   // read entry at read_index
        logic clear;      // empty table
        logic emit;       // register result
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;  // all candidates compared
        logic hit;        // a match was found
        logic is_record;
        logic is_read;
        logic is_clear;
    } dp_stat_t;

endpackage

[design/pflt_ctrl.sv]
// Sequencer for the packet flow log table.
module pflt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic              out_free,
    input  pflt_pkg::dp_stat_t stat,
    output logic              in_ready,
    output logic              out_load,
    output pflt_pkg::dp_cmd_t cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN, S_WRITE, S_SETTLE, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.is_record) begin
                    state_next = S_SCAN;
                end else if (stat.is_read) begin
                    cmd.read_req = 1'b1;
                    state_next   = S_SETTLE;
                end else begin
                    cmd.clear  = stat.is_clear;
                    state_next = S_SETTLE;
                end
            end
            S_SCAN: begin
                if (stat.hit || stat.scan_done) begin
                    state_next = S_WRITE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_WRITE: begin
                cmd.write_hit = stat.hit;
                cmd.write_new = !stat.hit;
                state_next    = S_SETTLE;
            end
            S_SETTLE: begin
                cmd.emit   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

[design/pflt_datapath.sv]
// Table memory, scan logic and result formatting.
module pflt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pflt_pkg::dp_cmd_t  cmd,
    output pflt_pkg::dp_stat_t stat,
    input  logic [1:0]         in_op,
    input  logic [31:0]        in_time,
    input  logic [31:0]        in_src,
    input  logic [31:0]        in_dst,
    input  logic [15:0]        in_sport,
    input  logic [15:0]        in_dport,
    input  logic [7:0]         in_proto,
    input  logic [2:0]         in_hook,
    input  logic [7:0]         in_action,
    input  logic [31:0]        in_reason,
    input  logic [5:0]         in_index,
    output pflt_pkg::entry_t   res_entry,
    output logic [6:0]         res_used
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    pflt_pkg::entry_t mem [TABLE_DEPTH];

    pflt_pkg::entry_t key_reg;
    logic [1:0]       op_reg;
    logic [5:0]       idx_reg;
    logic             ports_reg;
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    scan_reg;     // index of entry in rd_reg
    logic             rd_valid_reg;
    pflt_pkg::entry_t rd_reg;
    logic             hit_reg;
    logic [AW-1:0]    hit_idx_reg;
    logic [AW-1:0]    old_idx_reg;
    logic [31:0]      old_time_reg;
    pflt_pkg::entry_t res_reg;
    logic             res_zero_reg;
    logic [AW-1:0]    wr_idx;

    logic             match;
    logic [FW-1:0]    scan_lim;
    logic [FW-1:0]    rd_addr;

    assign scan_lim = fill_reg;
    assign match = rd_valid_reg && (scan_reg < scan_lim)
        && rd_reg.src_addr == key_reg.src_addr && rd_reg.dst_addr == key_reg.dst_addr
        && rd_reg.proto == key_reg.proto && rd_reg.hook == key_reg.hook
        && rd_reg.action == key_reg.action && rd_reg.reason == key_reg.reason
        && (!ports_reg || (rd_reg.l4_src == key_reg.l4_src
                           && rd_reg.l4_dst == key_reg.l4_dst));

    // Scan is done once every filled entry has been compared.
    always_comb begin
        stat.hit       = hit_reg;
        stat.scan_done = (scan_reg >= scan_lim);
        stat.is_record = (op_reg == pflt_pkg::OP_RECORD);
        stat.is_read   = (op_reg == pflt_pkg::OP_READ);
        stat.is_clear  = (op_reg == pflt_pkg::OP_CLEAR);
    end

    // On a match the scan index stays put, so rd_reg keeps the matched entry.
    assign rd_addr = cmd.load ? '0
                   : ((cmd.scan_step && !match) ? scan_reg + 1'b1 : scan_reg);

    // Memory read port, registered.
    always_ff @(posedge aclk) begin
        if (cmd.read_req) begin
            rd_reg <= mem[AW'({{(FW > 6 ? FW - 6 : 0){1'b0}}, idx_reg})];
        end else begin
            rd_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    // Memory write port.
    always_ff @(posedge aclk) begin
        if (cmd.write_hit) begin
            mem[hit_idx_reg].stamp <= key_reg.stamp;
            if (rd_reg.count != pflt_pkg::COUNT_MAX)
                mem[hit_idx_reg].count <= rd_reg.count + 32'd1;
        end else if (cmd.write_new) begin
            mem[wr_idx] <= key_reg;
        end
    end

    always_comb begin
        if (fill_reg < FW'(TABLE_DEPTH)) wr_idx = fill_reg[AW-1:0];
        else                             wr_idx = old_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            if (cmd.load) begin
                op_reg          <= in_op;
                idx_reg         <= in_index;
                ports_reg       <= (in_proto == pflt_pkg::PROTO_TCP)
                                || (in_proto == pflt_pkg::PROTO_UDP);
                key_reg.src_addr <= in_src;
                key_reg.dst_addr <= in_dst;
                key_reg.l4_src   <= ((in_proto == pflt_pkg::PROTO_TCP)
                    || (in_proto == pflt_pkg::PROTO_UDP)) ? in_sport : 16'd0;
                key_reg.l4_dst   <= ((in_proto == pflt_pkg::PROTO_TCP)
                    || (in_proto == pflt_pkg::PROTO_UDP)) ? in_dport : 16'd0;
                key_reg.proto    <= in_proto;
                key_reg.hook     <= in_hook;
                key_reg.action   <= in_action;
                key_reg.reason   <= in_reason;
                key_reg.stamp    <= in_time;
                key_reg.count    <= 32'd1;
                scan_reg         <= '0;
                rd_valid_reg     <= 1'b1;
                hit_reg          <= 1'b0;
                old_idx_reg      <= '0;
                old_time_reg     <= 32'hFFFF_FFFF;
            end
            if (cmd.scan_step) begin
                if (match) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= scan_reg[AW-1:0];
                end else begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (scan_reg == '0 || rd_reg.stamp < old_time_reg) begin
                    old_time_reg <= rd_reg.stamp;
                    old_idx_reg  <= scan_reg[AW-1:0];
                end
            end
            if (cmd.write_new && fill_reg < FW'(TABLE_DEPTH))
                fill_reg <= fill_reg + 1'b1;
            if (cmd.clear)
                fill_reg <= '0;
            if (cmd.emit) begin
                res_zero_reg <= 1'b1;
                if (op_reg == pflt_pkg::OP_RECORD) begin
                    res_zero_reg <= 1'b0;
                    if (hit_reg) begin
                        res_reg <= rd_reg;
                        res_reg.stamp <= key_reg.stamp;
                        res_reg.count <= (rd_reg.count != pflt_pkg::COUNT_MAX)
                                       ? rd_reg.count + 32'd1 : rd_reg.count;
                    end else begin
                        res_reg <= key_reg;
                    end
                end else if (op_reg == pflt_pkg::OP_READ) begin
                    res_reg <= rd_reg;
                    res_zero_reg <= !({{(FW > 6 ? FW - 6 : 0){1'b0}}, idx_reg} < fill_reg
                                      && 32'(idx_reg) < TABLE_DEPTH);
                end
            end
        end
    end

    assign res_entry = res_zero_reg ? '0 : res_reg;
    assign res_used  = 7'(fill_reg);
endmodule

[design/packet_flow_log_table.sv]
// Top level of the packet flow log table.
// Usage:
// - s_axis carries one command transfer; s_axis_tuser selects record event,
//   clear table or read entry. m_axis returns exactly one result transfer
//   per command.
// - A record event scans the table one entry per cycle (one memory read
//   port), stopping at the first match; with no match it also tracks the
//   oldest stamp and then appends or replaces.
// - One command is in flight at a time; s_axis_tready is high only when
//   the controller is idle, so the next command is taken only once the
//   previous result has been loaded into the output register.
// - Results sit in an output register. While the receiver stalls, one more
//   command can be taken; it completes and then holds until the register
//   frees, and no further command is taken meanwhile.
// - Reset empties the table (fill count to zero); entry memory needs no
//   clearing since entries at or above the fill count are never shown.
// - entries_used reports the fill count after each command.
module packet_flow_log_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tuser: operation[1:0]
    input  logic [1:0]   s_axis_tuser,
    // tdata, low bit up: event_time[31:0], source_address, dest_address,
    // source_port, dest_port, ip_protocol, hook_point, verdict_action,
    // verdict_reason, read_index; 185 bits, zero-filled to 192
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, low bit up: entry_time, entry_source_address, entry_dest_address,
    // entry_source_port, entry_dest_port, entry_protocol, entry_hook,
    // entry_action, entry_reason, hit_count, entries_used; 218 bits, to 224
    output logic [223:0] m_axis_tdata
);
    pflt_pkg::dp_cmd_t  cmd;
    pflt_pkg::dp_stat_t stat;
    pflt_pkg::entry_t   res_entry;
    logic [6:0]         res_used;
    logic               in_fire;
    logic               out_load;
    logic               out_valid_reg;
    logic [223:0]       out_data_reg;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    pflt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (!out_valid_reg),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    pflt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_axis_tuser),
        .in_time   (s_axis_tdata[31:0]),
        .in_src    (s_axis_tdata[63:32]),
        .in_dst    (s_axis_tdata[95:64]),
        .in_sport  (s_axis_tdata[111:96]),
        .in_dport  (s_axis_tdata[127:112]),
        .in_proto  (s_axis_tdata[135:128]),
        .in_hook   (s_axis_tdata[138:136]),
        .in_action (s_axis_tdata[146:139]),
        .in_reason (s_axis_tdata[178:147]),
        .in_index  (s_axis_tdata[184:179]),
        .res_entry (res_entry),
        .res_used  (res_used)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (out_load) begin
            out_data_reg <= {6'd0, res_used, res_entry.count, res_entry.reason,
                res_entry.action, res_entry.hook, res_entry.proto,
                res_entry.l4_dst, res_entry.l4_src, res_entry.dst_addr,
                res_entry.src_addr, res_entry.stamp};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
endmodule

[design/pflt_checker.sv]
// Port-level checks for the packet flow log table.
module pflt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [223:0] m_axis_tdata
);
    // One command in flight: no transfer in the cycle after a transfer.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accept while busy");

    // With no result waiting, none appears in the cycle after a command transfer.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result too early");

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Fill count never exceeds 64 on the output.
    a_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[217:211] <= 7'd64) else $error("fill count range");
endmodule

bind packet_flow_log_table pflt_checker u_pflt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
